### hdl/radial_displacement_map_gen_macros.svh
// Assertion helpers shared by the displacement map generator.
`ifndef RADIAL_DISPLACEMENT_MAP_GEN_MACROS_SVH
`define RADIAL_DISPLACEMENT_MAP_GEN_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RDM_ASSERT_IMPL(label, ck, rn, a, c, msg) \
    label: assert property (@(posedge ck) disable iff (!(rn)) (a) |-> (c)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RDM_ASSERT_NEXT(label, ck, rn, a, c, msg) \
    label: assert property (@(posedge ck) disable iff (!(rn)) (a) |=> (c)) else $error(msg);

`endif

### hdl/rdm_pkg.sv
// ----------------------------------------------------------------------------
// rdm_pkg
// Shared widths, constants and pipeline latencies of the displacement map
// generator.
// ----------------------------------------------------------------------------
`default_nettype none

package rdm_pkg;

    localparam int COORD_W  = 7;    // pixel index
    localparam int NORM_W   = 17;   // Q1.15 coordinate, signed
    localparam int RAD2_W   = 32;   // Q2.30 squared radius
    localparam int ROOT_W   = 16;   // Q1.15 radius
    localparam int INNER_W  = 16;   // Q0.16 inner radius
    localparam int BAND_W   = 17;   // Q0.16 band, 0..65536
    localparam int CODE_W   = 8;
    localparam int QUO_W    = 9;    // displacement quotient bits
    localparam int AMP_W    = 25;   // scaled magnitude, 2^-16 dropped

    localparam int SQRT_LAT = 4;
    localparam int BAND_LAT = 7;
    localparam int CODE_LAT = 6;
    localparam int PIPE_LAT = 2 + SQRT_LAT + BAND_LAT + CODE_LAT;

    localparam logic [INNER_W-1:0] INNER_RESET = 16'd38011;
    localparam logic [17:0]        SMOOTH_K    = 18'd196608;   // 3.0 in Q2.16
    localparam logic [ROOT_W-1:0]  LEN_ONE     = 16'd32768;    // 1.0 in Q1.15
    localparam logic [BAND_W-1:0]  BAND_ONE    = 17'd65536;
    localparam logic [CODE_W-1:0]  CODE_MID    = 8'd128;
    localparam logic [CODE_W-1:0]  CODE_MAX    = 8'd255;
    localparam logic [CODE_W-1:0]  CODE_MIN    = 8'd0;

endpackage

`default_nettype wire

### hdl/rdm_isqrt.sv
// ----------------------------------------------------------------------------
// rdm_isqrt
// Pipelined integer square root, two radicand bits per step, four steps
// per register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rdm_isqrt (
    input  logic                       clk,
    input  logic                       en,
    input  logic [rdm_pkg::RAD2_W-1:0] rad2,
    output logic [rdm_pkg::ROOT_W-1:0] root
);
    import rdm_pkg::*;

    localparam int STEPS = ROOT_W / SQRT_LAT;
    localparam int REM_W = ROOT_W + 4;

    logic [RAD2_W-1:0] v_reg    [SQRT_LAT];
    logic [REM_W-1:0]  rem_reg  [SQRT_LAT];
    logic [ROOT_W-1:0] root_reg [SQRT_LAT];

    genvar g;
    generate
        for (g = 0; g < SQRT_LAT; g++)
        begin : g_stage
            logic [RAD2_W-1:0] v_in;
            logic [REM_W-1:0]  rem_in;
            logic [ROOT_W-1:0] root_in;
            logic [REM_W-1:0]  rem_next;
            logic [ROOT_W-1:0] root_next;
            logic [REM_W-1:0]  cur;
            logic [REM_W-1:0]  trial;

            if (g == 0)
            begin : g_first
                assign v_in    = rad2;
                assign rem_in  = '0;
                assign root_in = '0;
            end
            else
            begin : g_rest
                assign v_in    = v_reg[g-1];
                assign rem_in  = rem_reg[g-1];
                assign root_in = root_reg[g-1];
            end

            always_comb
            begin
                rem_next  = rem_in;
                root_next = root_in;
                cur       = '0;
                trial     = '0;
                for (int j = 0; j < STEPS; j++)
                begin
                    // bring down the next bit pair and try root*4+1
                    cur   = {rem_next[REM_W-3:0],
                             v_in[2*(ROOT_W-1-(g*STEPS+j)) +: 2]};
                    trial = {2'b00, root_next, 2'b01};
                    if (cur >= trial)
                    begin
                        rem_next  = cur - trial;
                        root_next = {root_next[ROOT_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next  = cur;
                        root_next = {root_next[ROOT_W-2:0], 1'b0};
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    v_reg[g]    <= v_in;
                    rem_reg[g]  <= rem_next;
                    root_reg[g] <= root_next;
                end
            end
        end
    endgenerate

    assign root = root_reg[SQRT_LAT-1];

endmodule

`default_nettype wire

### hdl/rdm_band.sv
// ----------------------------------------------------------------------------
// rdm_band
// Smoothstep edge band: ramp division over four stages, then the cubic.
// ----------------------------------------------------------------------------
`default_nettype none

module rdm_band (
    input  logic                        clk,
    input  logic                        en,
    input  logic [rdm_pkg::ROOT_W-1:0]  radius,
    input  logic [rdm_pkg::INNER_W-1:0] inner,
    output logic [rdm_pkg::BAND_W-1:0]  band
);
    import rdm_pkg::*;

    localparam int DIV_ST = 4;
    localparam int STEPS  = INNER_W / DIV_ST;

    logic [BAND_W-1:0]  den;
    logic [BAND_W-1:0]  dia;
    logic [BAND_W-1:0]  diff;
    logic               above;

    logic [BAND_W-1:0]  rem_reg  [DIV_ST+1];
    logic [INNER_W-1:0] quo_reg  [DIV_ST+1];
    logic               zero_reg [DIV_ST+1];
    logic               sat_reg  [DIV_ST+1];

    logic [BAND_W-1:0]  ramp;
    logic [33:0]        ramp_sq;
    logic [BAND_W-1:0]  ramp_reg;
    logic [32:0]        ramp_sq_reg;
    logic [17:0]        factor;
    logic [50:0]        cubic;
    logic [BAND_W-1:0]  band_reg;

    assign den   = BAND_ONE - {1'b0, inner};
    assign dia   = {radius, 1'b0};
    assign above = dia > {1'b0, inner};
    assign diff  = dia - {1'b0, inner};

    // prep: flag the flat inside and the clamped rim
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= diff;
            quo_reg[0]  <= '0;
            zero_reg[0] <= !above;
            sat_reg[0]  <= diff >= den;
        end
    end

    genvar g;
    generate
        for (g = 0; g < DIV_ST; g++)
        begin : g_div
            logic [BAND_W-1:0]  rem_next;
            logic [INNER_W-1:0] quo_next;
            logic [BAND_W:0]    cur;

            always_comb
            begin
                rem_next = rem_reg[g];
                quo_next = quo_reg[g];
                cur      = '0;
                for (int j = 0; j < STEPS; j++)
                begin
                    cur = {rem_next, 1'b0};
                    if (cur >= {1'b0, den})
                    begin
                        rem_next = BAND_W'(cur - {1'b0, den});
                        quo_next = {quo_next[INNER_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = cur[BAND_W-1:0];
                        quo_next = {quo_next[INNER_W-2:0], 1'b0};
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[g+1]  <= rem_next;
                    quo_reg[g+1]  <= quo_next;
                    zero_reg[g+1] <= zero_reg[g];
                    sat_reg[g+1]  <= sat_reg[g];
                end
            end
        end
    endgenerate

    always_comb
    begin
        if (zero_reg[DIV_ST])
            ramp = '0;
        else if (sat_reg[DIV_ST])
            ramp = BAND_ONE;
        else
            ramp = {1'b0, quo_reg[DIV_ST]};
    end

    assign ramp_sq = ramp * ramp;
    assign factor  = SMOOTH_K - {ramp_reg, 1'b0};
    assign cubic   = ramp_sq_reg * factor;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ramp_reg    <= ramp;
            ramp_sq_reg <= ramp_sq[32:0];
            band_reg    <= cubic[48:32];
        end
    end

    assign band = band_reg;

endmodule

`default_nettype wire

### hdl/rdm_code.sv
// ----------------------------------------------------------------------------
// rdm_code
// One displacement axis: scale the coordinate by the band and 127, divide
// by the radius, then center on 128 and clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module rdm_code (
    input  logic                              clk,
    input  logic                              en,
    input  logic signed [rdm_pkg::NORM_W-1:0] coord,
    input  logic [rdm_pkg::BAND_W-1:0]        band,
    input  logic [rdm_pkg::ROOT_W-1:0]        radius,
    output logic [rdm_pkg::CODE_W-1:0]        code
);
    import rdm_pkg::*;

    localparam int DIV_ST = 3;
    localparam int STEPS  = QUO_W / DIV_ST;

    logic [NORM_W-1:0]   mag;
    logic [33:0]         prod;
    logic [33:0]         prod_reg;
    logic                neg_reg   [DIV_ST+2];
    logic [ROOT_W-1:0]   len_reg   [DIV_ST+2];
    logic [40:0]         scaled;
    logic [AMP_W-1:0]    rem_reg   [DIV_ST+1];
    logic [QUO_W-1:0]    quo_reg   [DIV_ST+1];
    logic                frac_reg  [DIV_ST+1];
    logic                ovf_reg   [DIV_ST+1];
    logic [QUO_W:0]      up;
    logic                inexact;
    logic [CODE_W-1:0]   code_next;
    logic [CODE_W-1:0]   code_reg;

    assign mag  = coord[NORM_W-1] ? NORM_W'(-coord) : NORM_W'(coord);
    assign prod = mag * band;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg   <= prod;
            neg_reg[0] <= coord[NORM_W-1];
            len_reg[0] <= (radius == '0) ? LEN_ONE : radius;
        end
    end

    // times 127, drop the 2^-16 part but remember whether it was nonzero
    assign scaled = {prod_reg, 7'b0} - {7'b0, prod_reg};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= scaled[40:16];
            quo_reg[0]  <= '0;
            frac_reg[0] <= |scaled[15:0];
            ovf_reg[0]  <= scaled[40:16] >= (AMP_W'(len_reg[0]) << QUO_W);
            neg_reg[1]  <= neg_reg[0];
            len_reg[1]  <= len_reg[0];
        end
    end

    genvar g;
    generate
        for (g = 0; g < DIV_ST; g++)
        begin : g_div
            logic [AMP_W-1:0] rem_next;
            logic [QUO_W-1:0] quo_next;
            logic [AMP_W-1:0] sub;

            always_comb
            begin
                rem_next = rem_reg[g];
                quo_next = quo_reg[g];
                sub      = '0;
                for (int j = 0; j < STEPS; j++)
                begin
                    sub = AMP_W'(len_reg[g+1]) << (QUO_W-1-(g*STEPS+j));
                    if (rem_next >= sub)
                    begin
                        rem_next = rem_next - sub;
                        quo_next[QUO_W-1-(g*STEPS+j)] = 1'b1;
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[g+1]  <= rem_next;
                    quo_reg[g+1]  <= quo_next;
                    frac_reg[g+1] <= frac_reg[g];
                    ovf_reg[g+1]  <= ovf_reg[g];
                    neg_reg[g+2]  <= neg_reg[g+1];
                    len_reg[g+2]  <= len_reg[g+1];
                end
            end
        end
    endgenerate

    // negative side rounds the offset up, so floor of 128 - x holds
    assign inexact = frac_reg[DIV_ST] || (rem_reg[DIV_ST] != '0);
    assign up      = {1'b0, quo_reg[DIV_ST]} + {{QUO_W{1'b0}}, inexact};

    always_comb
    begin
        if (neg_reg[DIV_ST+1])
        begin
            if (ovf_reg[DIV_ST] || up > (QUO_W+1)'(CODE_MID))
                code_next = CODE_MIN;
            else
                code_next = CODE_MID - up[CODE_W-1:0];
        end
        else
        begin
            if (ovf_reg[DIV_ST] || quo_reg[DIV_ST] > QUO_W'(CODE_MAX - CODE_MID))
                code_next = CODE_MAX;
            else
                code_next = CODE_MID + quo_reg[DIV_ST][CODE_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            code_reg <= code_next;
    end

    assign code = code_reg;

endmodule

`default_nettype wire

### hdl/radial_displacement_map_gen.sv
// ----------------------------------------------------------------------------
// radial_displacement_map_gen
// Per-pixel radial smoothstep displacement map: for one (column, row) of a
// square map, returns the red and green displacement bytes.
//
// Channels: s_* takes one pixel coordinate per beat, m_* returns one beat
// with both displacement bytes for each input beat, in order. cfg_* writes
// the inner radius (Q0.16 of the half-width); write it only while no pixel
// is in flight. cfg_ready is always high.
// Throughput: one pixel per clock while the output is not stalled; the
// depth is set by the 16-bit square root (4 stages), the ramp division
// (4 stages) and the per-axis radius division (3 stages).
// Reset: empties the pipeline and loads the inner radius with 0.58.
// Stall: while m_tvalid is high and m_tready low, the whole pipeline holds
// and s_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none
`include "radial_displacement_map_gen_macros.svh"

module radial_displacement_map_gen #(
    parameter int MAP_SIZE = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,     // [6:0] column, [13:7] row, [15:14] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,     // [7:0] disp_x_code, [15:8] disp_y_code
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data     // inner_radius
);
    import rdm_pkg::*;

    localparam int     TABLE_N = 1 << COORD_W;
    localparam longint SPAN    = MAP_SIZE - 1;
    localparam int     N_DLY   = 1 + SQRT_LAT + BAND_LAT;   // coordinate to band output

    logic                      en;
    logic [PIPE_LAT-1:0]       vld_reg;
    logic [INNER_W-1:0]        inner_reg;

    logic signed [NORM_W-1:0]  norm_lut [TABLE_N];
    logic [COORD_W-1:0]        column;
    logic [COORD_W-1:0]        row;
    logic signed [NORM_W-1:0]  nx_reg;
    logic signed [NORM_W-1:0]  ny_reg;
    logic signed [33:0]        sq_x;
    logic signed [33:0]        sq_y;
    logic [RAD2_W-1:0]         rad2_reg;
    logic [ROOT_W-1:0]         radius;
    logic [BAND_W-1:0]         band;

    logic signed [NORM_W-1:0]  nx_dly_reg [N_DLY];
    logic signed [NORM_W-1:0]  ny_dly_reg [N_DLY];
    logic [ROOT_W-1:0]         rad_dly_reg [BAND_LAT];

    logic [CODE_W-1:0]         code_x;
    logic [CODE_W-1:0]         code_y;

    // Advance everything together unless the output beat is blocked.
    assign en        = !vld_reg[PIPE_LAT-1] || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inner_reg <= INNER_RESET;
        else if (cfg_valid)
            inner_reg <= cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[PIPE_LAT-2:0], s_tvalid};
    end

    // Coordinate table: index saturated to the map, scaled to -1..1 in Q1.15,
    // rounded half away from zero. Built entirely at elaboration.
    genvar gi;
    generate
        for (gi = 0; gi < TABLE_N; gi++)
        begin : g_lut
            localparam longint CI  = (gi > SPAN) ? SPAN : gi;
            localparam longint NUM = 2 * CI - SPAN;
            localparam longint MAG = ((NUM < 0) ? -NUM : NUM) * 32768;
            localparam longint QV  = (MAG + SPAN / 2) / SPAN;
            localparam longint VAL = (NUM < 0) ? -QV : QV;
            assign norm_lut[gi] = NORM_W'(VAL);
        end
    endgenerate

    assign column = s_tdata[COORD_W-1:0];
    assign row    = s_tdata[2*COORD_W-1:COORD_W];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nx_reg <= norm_lut[column];
            ny_reg <= norm_lut[row];
        end
    end

    // Squared radius in Q2.30; at most 2.0, so 32 bits hold it.
    assign sq_x = nx_reg * nx_reg;
    assign sq_y = ny_reg * ny_reg;

    always_ff @(posedge clk)
    begin
        if (en)
            rad2_reg <= sq_x[RAD2_W-1:0] + sq_y[RAD2_W-1:0];
    end

    rdm_isqrt u_isqrt (
        .clk  (clk),
        .en   (en),
        .rad2 (rad2_reg),
        .root (radius)
    );

    rdm_band u_band (
        .clk    (clk),
        .en     (en),
        .radius (radius),
        .inner  (inner_reg),
        .band   (band)
    );

    // Hold the coordinates and the radius until the band catches up.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nx_dly_reg[0]  <= nx_reg;
            ny_dly_reg[0]  <= ny_reg;
            rad_dly_reg[0] <= radius;
            for (int k = 1; k < N_DLY; k++)
            begin
                nx_dly_reg[k] <= nx_dly_reg[k-1];
                ny_dly_reg[k] <= ny_dly_reg[k-1];
            end
            for (int k = 1; k < BAND_LAT; k++)
                rad_dly_reg[k] <= rad_dly_reg[k-1];
        end
    end

    rdm_code u_code_x (
        .clk    (clk),
        .en     (en),
        .coord  (nx_dly_reg[N_DLY-1]),
        .band   (band),
        .radius (rad_dly_reg[BAND_LAT-1]),
        .code   (code_x)
    );

    rdm_code u_code_y (
        .clk    (clk),
        .en     (en),
        .coord  (ny_dly_reg[N_DLY-1]),
        .band   (band),
        .radius (rad_dly_reg[BAND_LAT-1]),
        .code   (code_y)
    );

    assign m_tvalid = vld_reg[PIPE_LAT-1];
    assign m_tdata  = {code_y, code_x};

    `RDM_ASSERT_NEXT(a_stall_holds, clk, rst_n, m_tvalid && !m_tready, $stable(vld_reg), "pipeline moved while output stalled")
    `RDM_ASSERT_NEXT(a_valid_shifts, clk, rst_n, en, vld_reg[PIPE_LAT-1:1] == $past(vld_reg[PIPE_LAT-2:0]), "valid bits did not advance")
    `RDM_ASSERT_NEXT(a_accept_enters, clk, rst_n, s_tvalid && s_tready, vld_reg[0], "accepted beat missing from pipeline")
    `RDM_ASSERT_IMPL(a_block_cause, clk, rst_n, !s_tready, m_tvalid && !m_tready, "input blocked without output stall")

endmodule

`default_nettype wire
